/* sv/fcsg_pkg.sv */
// shared types and constants for the filled circle span generator
package fcsg_pkg;

	localparam int MAX_RADIUS = 31;
	localparam int COORD_W    = 15;
	localparam int OUT_W      = 16;
	localparam int RAD_W      = 5;
	localparam int OFS_W      = RAD_W + 1;
	localparam int SQ_W       = 2 * RAD_W;

	typedef enum logic {
		ST_IDLE,
		ST_ISSUE
	} state_t;

	typedef struct packed {
		logic load;
		logic issue;
	} ctrl_cmd_t;

	typedef struct packed {
		logic adv;
		logic final_row;
	} dp_status_t;

	typedef struct packed {
		logic signed [OUT_W-1:0]   row;
		logic signed [COORD_W-1:0] cx;
		logic                      last;
		logic [SQ_W-1:0]           rem_n;
		logic [RAD_W-1:0]          root;
	} pipe_t;

endpackage

/* sv/fcsg_isqrt_stage.sv */
// one registered bit step of the span half-width square root
module fcsg_isqrt_stage #(
	parameter int BIT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           vld_in,
	input  fcsg_pkg::pipe_t d,
	output logic           vld_out,
	output fcsg_pkg::pipe_t q
);
	import fcsg_pkg::*;

	logic [RAD_W-1:0] cand;
	logic [SQ_W-1:0]  sq;
	pipe_t            nxt;
	pipe_t            stg_s1;
	logic             vld_s1;

	assign cand = d.root | (RAD_W'(1) << BIT);
	assign sq   = SQ_W'(cand) * SQ_W'(cand);

	always_comb begin
		nxt = d;
		if (sq <= d.rem_n) begin
			nxt.root = cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stg_s1 <= nxt;
		end
	end

	assign vld_out = vld_s1;
	assign q       = stg_s1;

endmodule

/* sv/fcsg_datapath.sv */
// row counter, radius square pipeline and span output register
module fcsg_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fcsg_pkg::ctrl_cmd_t                  cmd,
	output fcsg_pkg::dp_status_t                 status,
	input  logic signed [fcsg_pkg::COORD_W-1:0]  center_x,
	input  logic signed [fcsg_pkg::COORD_W-1:0]  center_y,
	input  logic [fcsg_pkg::RAD_W-1:0]           radius,
	output logic                                 span_valid,
	input  logic                                 span_ready,
	output logic signed [fcsg_pkg::OUT_W-1:0]    row,
	output logic signed [fcsg_pkg::OUT_W-1:0]    x_start,
	output logic signed [fcsg_pkg::OUT_W-1:0]    x_end,
	output logic                                 last_span
);
	import fcsg_pkg::*;

	localparam int NSTG = RAD_W;

	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic [RAD_W-1:0]          r_q;
	logic signed [OFS_W-1:0]   y_q;
	logic [RAD_W-1:0]          r_sat;
	logic [OFS_W-1:0]          y_neg;
	logic [RAD_W-1:0]          y_abs;
	logic [SQ_W-1:0]           r2;
	logic [SQ_W-1:0]           y2;
	logic                      adv;
	pipe_t                     head;
	pipe_t                     stg_s1;
	logic                      vld_s1;
	pipe_t                     stg   [0:NSTG];
	logic                      vld   [0:NSTG];
	logic                      vld_s7;
	logic signed [OUT_W-1:0]   row_s7;
	logic signed [OUT_W-1:0]   xs_s7;
	logic signed [OUT_W-1:0]   xe_s7;
	logic                      last_s7;

	assign adv   = !vld_s7 || span_ready;
	assign r_sat = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;
	assign y_neg = -y_q;
	assign y_abs = y_q[OFS_W-1] ? y_neg[RAD_W-1:0] : y_q[RAD_W-1:0];
	assign r2    = SQ_W'(r_q) * SQ_W'(r_q);
	assign y2    = SQ_W'(y_abs) * SQ_W'(y_abs);

	assign status.adv       = adv;
	assign status.final_row = (y_q == {1'b0, r_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			y_q <= '0;
		end else if (cmd.load) begin
			r_q <= r_sat;
			y_q <= -{1'b0, r_sat};
		end else if (cmd.issue) begin
			y_q <= y_q + OFS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q <= center_x;
			cy_q <= center_y;
		end
	end

	always_comb begin
		head.row   = {cy_q[COORD_W-1], cy_q} + {{(OUT_W-OFS_W){y_q[OFS_W-1]}}, y_q};
		head.cx    = cx_q;
		head.last  = status.final_row;
		head.rem_n = r2 - y2;
		head.root  = '0;
	end

	// first stage: remaining square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stg_s1 <= head;
		end
	end

	assign vld[0] = vld_s1;
	assign stg[0] = stg_s1;

	// one root bit per stage, msb first
	for (genvar k = 0; k < NSTG; k++) begin : g_sqrt
		fcsg_isqrt_stage #(
			.BIT(NSTG - 1 - k)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_in (vld[k]),
			.d      (stg[k]),
			.vld_out(vld[k+1]),
			.q      (stg[k+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s7  <= stg[NSTG].row;
			xs_s7   <= {stg[NSTG].cx[COORD_W-1], stg[NSTG].cx}
				- {{(OUT_W-RAD_W){1'b0}}, stg[NSTG].root};
			xe_s7   <= {stg[NSTG].cx[COORD_W-1], stg[NSTG].cx}
				+ {{(OUT_W-RAD_W){1'b0}}, stg[NSTG].root};
			last_s7 <= stg[NSTG].last;
		end
	end

	assign span_valid = vld_s7;
	assign row        = row_s7;
	assign x_start    = xs_s7;
	assign x_end      = xe_s7;
	assign last_span  = last_s7;

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 |-> (xe_s7 >= xs_s7))
		else $error("span end left of span start");

	a_load_offset: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (y_q[OFS_W-1] || y_q == '0))
		else $error("row offset not started at minus radius");

	a_last_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && adv && status.final_row) |=> (vld[0] && stg[0].last))
		else $error("final row issued without last tag");

endmodule

/* sv/fcsg_ctrl.sv */
// controller state machine for circle load and row issue
module fcsg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 circle_valid,
	output logic                 circle_ready,
	input  fcsg_pkg::dp_status_t status,
	output fcsg_pkg::ctrl_cmd_t  cmd
);
	import fcsg_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt    = state_q;
		circle_ready = 1'b0;
		cmd.load     = 1'b0;
		cmd.issue    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				circle_ready = 1'b1;
				if (circle_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				cmd.issue = status.adv;
				if (status.adv && status.final_row) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/filled_circle_span_generator_core.sv */
// top level of the filled circle span generator
// a circle's first span passes the remaining square, root bit and output registers
// throughput: one span per cycle from the row issue counter while not stalled
// 2*r+1 spans per circle; a new circle is taken in the cycle after the last row
// of the previous one issues
// reset: arst_n clears the controller and all pipeline valid bits, block idle
module filled_circle_span_generator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                circle_valid,
	output logic                                circle_ready,
	input  logic signed [fcsg_pkg::COORD_W-1:0] center_x,
	input  logic signed [fcsg_pkg::COORD_W-1:0] center_y,
	input  logic [fcsg_pkg::RAD_W-1:0]          radius,
	output logic                                span_valid,
	input  logic                                span_ready,
	output logic signed [fcsg_pkg::OUT_W-1:0]   row,
	output logic signed [fcsg_pkg::OUT_W-1:0]   x_start,
	output logic signed [fcsg_pkg::OUT_W-1:0]   x_end,
	output logic                                last_span
);
	import fcsg_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	fcsg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.circle_valid(circle_valid),
		.circle_ready(circle_ready),
		.status      (status),
		.cmd         (cmd)
	);

	fcsg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.span_valid(span_valid),
		.span_ready(span_ready),
		.row       (row),
		.x_start   (x_start),
		.x_end     (x_end),
		.last_span (last_span)
	);

endmodule
